/* sv/trs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape request sequencer package
// Shared types, codes and constants of the tape request sequencer.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int UNITS_DEF       = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int RETRY_LIMIT_DEF = 10;

    // Input operation codes.
    localparam logic [1:0] OP_OPEN     = 2'd0;
    localparam logic [1:0] OP_POSITION = 2'd1;
    localparam logic [1:0] OP_REQUEST  = 2'd2;
    localparam logic [1:0] OP_COMPLETE = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_CMD     = 2'd0;
    localparam logic [1:0] KIND_OK      = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_CLEARED = 2'd3;

    // Drive function codes.
    localparam logic [2:0] FN_NONE   = 3'd0;
    localparam logic [2:0] FN_READ   = 3'd1;
    localparam logic [2:0] FN_WRITE  = 3'd2;
    localparam logic [2:0] FN_SPFWD  = 3'd4;
    localparam logic [2:0] FN_SPREV  = 3'd5;
    localparam logic [2:0] FN_WRGAP  = 3'd6;
    localparam logic [2:0] FN_REWIND = 3'd7;

    localparam logic [15:0] LIMIT_MAX = 16'hFFFF;

    // Drive phase of the request at the head of the queue.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEEK = 2'd1,
        PH_IO   = 2'd2
    } t_phase;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_START,
        ST_EMIT,
        ST_END
    } t_state;

    // Datapath commands issued by the controller.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_EXEC,
        CMD_READ_HEAD,
        CMD_START,
        CMD_PUT_END
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
    } t_cmd;

    // Status reported by the datapath.
    typedef struct packed {
        logic want_start;
        logic exec_emit;
        logic queue_empty;
        logic start_done;
        logic out_full;
    } t_status;

    // One queued request.
    typedef struct packed {
        logic [2:0]  unit;
        logic [15:0] block;
        logic        is_read;
        logic        is_raw;
        logic [7:0]  tag;
        logic [15:0] wcount;
        logic [17:0] addr;
    } t_entry;

    // One result word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tag;
        logic [2:0]  unit;
        logic [2:0]  func;
        logic [15:0] count;
        logic [17:0] addr;
        logic [15:0] resid;
        logic        last;
    } t_result;

    function automatic logic [15:0] limit_after(input logic [15:0] b);
        limit_after = (b == LIMIT_MAX) ? LIMIT_MAX : b + 16'd1;
    endfunction

endpackage

/* sv/tape_request_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape request sequencer
// Queues block requests for several tape units and issues drive commands.
// ----------------------------------------------------------------------------
// Usage: input words (open, set position, queue request, drive completion)
// arrive on the i_in_valid / o_in_ready channel; result words leave on
// o_out_valid / i_out_ready, the final one of each input word with o_last.
// One word is processed at a time. A word is executed; then, when a start is
// wanted, the start loop at the head of the queue reads the request memory
// once per entry it visits, until a request starts or the queue is empty;
// finally the last result is marked. Results are held one word back so that
// the last result can be marked; a stalled receiver holds the block in its
// current step until the output register frees. Reset returns the unit
// tables to their open state, empties the queue and returns to idle.
// ----------------------------------------------------------------------------
module tape_request_sequencer #(
    parameter int UNITS       = trs_pkg::UNITS_DEF,
    parameter int QUEUE_DEPTH = trs_pkg::QUEUE_DEPTH_DEF,
    parameter int RETRY_LIMIT = trs_pkg::RETRY_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_unit,
    input  logic [15:0] i_block,
    input  logic        i_is_read,
    input  logic        i_is_raw,
    input  logic [7:0]  i_tag,
    input  logic [15:0] i_word_count,
    input  logic [17:0] i_memory_address,
    input  logic [2:0]  i_drive_status,
    input  logic [15:0] i_residual_count,
    input  logic        i_ready_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tag_res,
    output logic [2:0]  o_unit_res,
    output logic [2:0]  o_function_res,
    output logic [15:0] o_tape_count,
    output logic [17:0] o_transfer_address,
    output logic [15:0] o_residual,
    output logic        o_last
);

    trs_pkg::t_cmd    cmd;
    trs_pkg::t_status status;
    trs_pkg::t_result result;

    trs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    trs_dpath #(
        .UNITS       (UNITS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .RETRY_LIMIT (RETRY_LIMIT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_take        (i_in_valid && o_in_ready),
        .i_operation      (i_operation),
        .i_unit           (i_unit),
        .i_block          (i_block),
        .i_is_read        (i_is_read),
        .i_is_raw         (i_is_raw),
        .i_tag            (i_tag),
        .i_word_count     (i_word_count),
        .i_memory_address (i_memory_address),
        .i_drive_status   (i_drive_status),
        .i_residual_count (i_residual_count),
        .i_ready_req      (i_ready_req),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result         (result)
    );

    assign o_kind             = result.kind;
    assign o_tag_res          = result.tag;
    assign o_unit_res         = result.unit;
    assign o_function_res     = result.func;
    assign o_tape_count       = result.count;
    assign o_transfer_address = result.addr;
    assign o_residual         = result.resid;
    assign o_last             = result.last;

endmodule

/* sv/trs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape request sequencer controller
// Steps each accepted word through execution and the start loop at the
// head of the queue, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module trs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  trs_pkg::t_status  i_status,
    output trs_pkg::t_cmd     o_cmd
);

    trs_pkg::t_state r_state, n_state;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            trs_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = trs_pkg::ST_DECIDE;
            end
            trs_pkg::ST_DECIDE: begin
                if (i_status.out_full) n_state = trs_pkg::ST_DECIDE;
                else if (i_status.want_start) n_state = trs_pkg::ST_READ;
                else n_state = trs_pkg::ST_END;
            end
            trs_pkg::ST_READ: begin
                if (i_status.queue_empty) n_state = trs_pkg::ST_END;
                else n_state = trs_pkg::ST_START;
            end
            trs_pkg::ST_START: begin
                if (i_status.out_full) n_state = trs_pkg::ST_START;
                else if (i_status.start_done) n_state = trs_pkg::ST_END;
                else n_state = trs_pkg::ST_READ;
            end
            trs_pkg::ST_END: begin
                if (!i_status.out_full) n_state = trs_pkg::ST_IDLE;
            end
            default: n_state = trs_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd.op   = trs_pkg::CMD_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            trs_pkg::ST_IDLE: o_in_ready = 1'b1;
            trs_pkg::ST_DECIDE: begin
                if (!i_status.out_full) o_cmd.op = trs_pkg::CMD_EXEC;
            end
            trs_pkg::ST_READ: begin
                if (!i_status.queue_empty) o_cmd.op = trs_pkg::CMD_READ_HEAD;
            end
            trs_pkg::ST_START: begin
                if (!i_status.out_full) o_cmd.op = trs_pkg::CMD_START;
            end
            trs_pkg::ST_END: begin
                if (!i_status.out_full) o_cmd.op = trs_pkg::CMD_PUT_END;
            end
            default: o_cmd.op = trs_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= trs_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* sv/trs_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape request sequencer datapath
// Unit tables, request queue, retry counter and the result register.
// Results are held back one word so that the last one can be marked.
// ----------------------------------------------------------------------------
module trs_dpath #(
    parameter int UNITS       = trs_pkg::UNITS_DEF,
    parameter int QUEUE_DEPTH = trs_pkg::QUEUE_DEPTH_DEF,
    parameter int RETRY_LIMIT = trs_pkg::RETRY_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_take,
    input  logic [1:0]        i_operation,
    input  logic [2:0]        i_unit,
    input  logic [15:0]       i_block,
    input  logic              i_is_read,
    input  logic              i_is_raw,
    input  logic [7:0]        i_tag,
    input  logic [15:0]       i_word_count,
    input  logic [17:0]       i_memory_address,
    input  logic [2:0]        i_drive_status,
    input  logic [15:0]       i_residual_count,
    input  logic              i_ready_req,
    input  trs_pkg::t_cmd     i_cmd,
    output trs_pkg::t_status  o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output trs_pkg::t_result  o_result
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam logic [FW-1:0] FULL = FW'(QUEUE_DEPTH);
    localparam logic [3:0] RLIM = 4'(RETRY_LIMIT);

    // Unit tables.
    logic [15:0] r_pos   [UNITS];
    logic [15:0] r_limit [UNITS];
    logic [UNITS-1:0] r_offline;

    // Request queue.
    trs_pkg::t_entry r_mem [QUEUE_DEPTH];
    trs_pkg::t_entry r_head;
    logic [QW-1:0] r_qhead, r_qtail;
    logic [FW-1:0] r_fill;
    trs_pkg::t_phase r_phase;
    logic [3:0] r_retry;

    // Latched input word.
    logic [1:0]  r_op;
    logic [2:0]  r_unit;
    logic [15:0] r_block;
    logic        r_is_read, r_is_raw, r_ready;
    logic [7:0]  r_tag;
    logic [15:0] r_wcount;
    logic [17:0] r_addr;
    logic [2:0]  r_dstat;
    logic [15:0] r_resid;

    // Pending result and output register.
    trs_pkg::t_result r_pend;
    logic r_pend_v;
    trs_pkg::t_result r_out;
    logic r_out_v;

    // Execution decode.
    logic        unit_ok;
    logic [UW-1:0] uix;
    logic [15:0] lim_u;
    logic        req_fail, req_clear, enq;
    logic [UW-1:0] hix;
    logic [15:0] hpos;
    logic        soft_err, retry_again;
    logic [3:0]  retry_inc;
    logic        cmpl_act, cmpl_done, start_drop;

    assign unit_ok = ({1'b0, r_unit} < 4'(UNITS));
    assign uix     = UW'(r_unit);
    assign lim_u   = r_limit[uix];
    assign req_fail  = !unit_ok || (r_fill >= FULL) || (lim_u < r_block);
    assign req_clear = (lim_u == r_block) && r_is_read;
    assign enq = (i_cmd.op == trs_pkg::CMD_EXEC) && (r_op == trs_pkg::OP_REQUEST)
                 && !req_fail && !req_clear;
    // Queued units are always in range, so the head unit indexes directly.
    assign hix  = UW'(r_head.unit);
    assign hpos = r_pos[hix];
    assign soft_err = r_dstat[0] && (r_dstat[2:1] == 2'b00)
                      && (r_phase == trs_pkg::PH_IO);
    assign retry_inc   = (r_retry == 4'hF) ? r_retry : r_retry + 4'd1;
    assign retry_again = soft_err && (retry_inc < RLIM);
    assign cmpl_act    = (r_phase != trs_pkg::PH_IDLE) && (r_fill != '0);
    assign cmpl_done   = cmpl_act && !retry_again
                         && (r_dstat[0] || r_phase == trs_pkg::PH_IO);
    assign start_drop  = r_offline[hix] || !r_ready;

    // A new result may be pushed only if the pending slot can move on.
    logic slot_free;
    assign slot_free = !r_pend_v || !r_out_v || i_out_ready;

    assign o_status.out_full    = !slot_free;
    assign o_status.want_start  =
        ((r_op == trs_pkg::OP_REQUEST) && !req_fail && !req_clear
         && (r_phase == trs_pkg::PH_IDLE))
        || ((r_op == trs_pkg::OP_COMPLETE) && cmpl_act);
    assign o_status.queue_empty = (r_fill == '0);
    assign o_status.exec_emit   = 1'b0;
    assign o_status.start_done  = !start_drop;

    assign o_out_valid = r_out_v;
    assign o_result    = r_out;

    trs_pkg::t_result push;
    logic push_v;
    logic mark_last;
    trs_pkg::t_result pend_fin;

    // Result word produced by the current command.
    always_comb begin
        push      = '0;
        push_v    = 1'b0;
        mark_last = 1'b0;
        unique case (i_cmd.op)
            trs_pkg::CMD_EXEC: begin
                if (r_op == trs_pkg::OP_REQUEST && (req_fail || req_clear)) begin
                    push_v    = 1'b1;
                    push.kind = req_fail ? trs_pkg::KIND_ERROR : trs_pkg::KIND_CLEARED;
                    push.tag  = r_tag;
                    push.unit = r_unit;
                end else if (r_op == trs_pkg::OP_COMPLETE && cmpl_done) begin
                    push_v     = 1'b1;
                    push.kind  = r_dstat[0] ? trs_pkg::KIND_ERROR : trs_pkg::KIND_OK;
                    push.tag   = r_head.tag;
                    push.unit  = r_head.unit;
                    push.resid = r_resid;
                end
            end
            trs_pkg::CMD_START: begin
                push_v    = 1'b1;
                push.tag  = r_head.tag;
                push.unit = r_head.unit;
                if (start_drop) begin
                    push.kind = trs_pkg::KIND_ERROR;
                end else if (hpos != r_head.block) begin
                    push.kind = trs_pkg::KIND_CMD;
                    if (hpos < r_head.block) begin
                        push.func  = trs_pkg::FN_SPFWD;
                        push.count = hpos - r_head.block;
                    end else if (r_head.block == '0) begin
                        push.func  = trs_pkg::FN_REWIND;
                    end else begin
                        push.func  = trs_pkg::FN_SPREV;
                        push.count = r_head.block - hpos;
                    end
                end else begin
                    push.kind  = trs_pkg::KIND_CMD;
                    push.func  = r_head.is_read ? trs_pkg::FN_READ
                               : (r_retry != '0 ? trs_pkg::FN_WRGAP : trs_pkg::FN_WRITE);
                    push.count = {r_head.wcount[14:0], 1'b0};
                    push.addr  = r_head.addr;
                end
            end
            trs_pkg::CMD_PUT_END: mark_last = 1'b1;
            default: ;
        endcase
    end

    // Pending word with its last mark set.
    always_comb begin
        pend_fin      = r_pend;
        pend_fin.last = 1'b1;
    end

    // Input word latch.
    always_ff @(posedge i_clk) begin
        if (i_in_take) begin
            r_op <= i_operation; r_unit <= i_unit; r_block <= i_block;
            r_is_read <= i_is_read; r_is_raw <= i_is_raw; r_tag <= i_tag;
            r_wcount <= i_word_count; r_addr <= i_memory_address;
            r_dstat <= i_drive_status; r_resid <= i_residual_count;
            r_ready <= i_ready_req;
        end
    end

    // Request memory: write at the tail, registered read of the head.
    always_ff @(posedge i_clk) begin
        if (i_rst_n && enq) begin
            r_mem[r_qtail] <= '{unit: r_unit, block: r_block,
                is_read: r_is_read, is_raw: r_is_raw, tag: r_tag,
                wcount: r_wcount, addr: r_addr};
        end
        if (i_cmd.op == trs_pkg::CMD_READ_HEAD) r_head <= r_mem[r_qhead];
    end

    // Main sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < UNITS; i++) begin
                r_pos[i]   <= '0;
                r_limit[i] <= trs_pkg::LIMIT_MAX;
            end
            r_offline    <= '0;
            r_qhead      <= '0;
            r_qtail      <= '0;
            r_fill       <= '0;
            r_phase      <= trs_pkg::PH_IDLE;
            r_retry      <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                trs_pkg::CMD_EXEC: begin
                    unique case (r_op)
                        trs_pkg::OP_OPEN: begin
                            if (unit_ok) begin
                                r_offline[uix] <= 1'b0;
                                r_pos[uix]     <= '0;
                                r_limit[uix]   <= trs_pkg::LIMIT_MAX;
                            end
                        end
                        trs_pkg::OP_POSITION: begin
                            if (unit_ok) begin
                                r_pos[uix]   <= r_block;
                                r_limit[uix] <= trs_pkg::limit_after(r_block);
                            end
                        end
                        trs_pkg::OP_REQUEST: begin
                            if (!req_fail && !req_clear) begin
                                if (!r_is_read)
                                    r_limit[uix] <= trs_pkg::limit_after(r_block);
                                r_qtail <= (r_qtail == QW'(QUEUE_DEPTH - 1)) ? '0
                                           : r_qtail + 1'b1;
                                r_fill  <= r_fill + 1'b1;
                            end
                        end
                        trs_pkg::OP_COMPLETE: begin
                            if (cmpl_act) begin
                                if (retry_again) begin
                                    r_retry <= retry_inc;
                                    r_pos[hix] <= hpos + 16'd1;
                                    r_phase <= trs_pkg::PH_IDLE;
                                end else if (cmpl_done) begin
                                    if (r_dstat[0] && !soft_err && !r_head.is_raw
                                        && !r_dstat[2])
                                        r_offline[hix] <= 1'b1;
                                    r_retry <= '0;
                                    r_pos[hix] <= hpos + 16'd1;
                                    r_qhead <= (r_qhead == QW'(QUEUE_DEPTH - 1)) ? '0
                                               : r_qhead + 1'b1;
                                    r_fill  <= r_fill - 1'b1;
                                    r_phase <= trs_pkg::PH_IDLE;
                                end else begin
                                    r_pos[hix] <= r_head.block;
                                    r_phase <= trs_pkg::PH_IDLE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                trs_pkg::CMD_START: begin
                    if (start_drop) begin
                        r_qhead <= (r_qhead == QW'(QUEUE_DEPTH - 1)) ? '0
                                   : r_qhead + 1'b1;
                        r_fill  <= r_fill - 1'b1;
                    end else if (hpos != r_head.block) begin
                        r_phase <= trs_pkg::PH_SEEK;
                    end else begin
                        r_phase <= trs_pkg::PH_IO;
                    end
                end
                default: ;
            endcase

            // Result staging: pending word moves to the output when a new one
            // arrives or at the end of the input word, marked last then.
            if (push_v) begin
                r_pend   <= push;
                r_pend_v <= 1'b1;
            end else if (mark_last && r_pend_v) begin
                r_pend_v <= 1'b0;
            end
            if (push_v && r_pend_v) begin
                r_out   <= r_pend;
                r_out_v <= 1'b1;
            end else if (mark_last && r_pend_v) begin
                r_out   <= pend_fin;
                r_out_v <= 1'b1;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Queue fill never exceeds its depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL) else $error("queue overfilled");
    // A busy drive phase implies a queued request.
    a_phase_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != trs_pkg::PH_IDLE) |-> (r_fill != '0)) else $error("phase without entry");
    // Output word held while stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_out_ready) |=> (r_out_v && $stable(r_out)))
        else $error("output changed under stall");

endmodule
